### design/nlqt_pkg.sv
// ----------------------------------------------------------------------------
// nlqt_pkg: shared types and constants of the neighbor link quality table
// Transfer payloads, table entry layout, search token and write-back bundle.
// ----------------------------------------------------------------------------
package nlqt_pkg;

  localparam int ALPHA_W = 9;    // smoothing weight, value/256
  localparam int AVG_W   = 16;   // stored retransmission average, Q8
  localparam int DL_W    = 9;    // delivery ratio, Q8, 256 is 1.0
  localparam int CFG_IDX_W = 2;

  localparam logic [ALPHA_W-1:0] Q8_ONE = 9'd256;
  localparam logic [DL_W-1:0]    DL_ONE = 9'd256;

  // known flag bit positions
  localparam int FLAG_RX = 0;
  localparam int FLAG_TX = 1;
  localparam int FLAG_DL = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RECEIVED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SENT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_DELIVERY = 2'd2;

  typedef struct packed {
    logic [31:0] neighbor_address;
    logic        rx_count_valid;
    logic [7:0]  rx_count;
    logic        tx_count_valid;
    logic [7:0]  tx_count;
    logic        outcome_valid;
    logic        outcome_success;
  } obs_t;

  typedef struct packed {
    logic        was_present;
    logic        table_full;
    logic        rx_known;
    logic [11:0] rx_estimate;
    logic        tx_known;
    logic [11:0] tx_estimate;
    logic        delivery_known;
    logic [8:0]  delivery_estimate;
  } res_t;

  typedef struct packed {
    logic [2:0]       known;
    logic [AVG_W-1:0] rx_avg;
    logic [AVG_W-1:0] tx_avg;
    logic [DL_W-1:0]  dl_avg;
  } entry_t;

  // search token walking down the cell row
  typedef struct packed {
    logic [31:0] addr;
    logic        found;
    entry_t      ent;
  } token_t;

  // write-back broadcast to all cells
  typedef struct packed {
    logic        en;
    logic        insert;
    logic [31:0] addr;
    entry_t      ent;
  } wb_t;

  function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
    clamp_alpha = (a > Q8_ONE) ? Q8_ONE : a;
  endfunction

endpackage

### design/nlqt_cell.sv
// ----------------------------------------------------------------------------
// nlqt_cell: one table entry of the cell row
// Matches the passing token against its address and hands it on, and takes
// the write-back when it owns the address or is the first free cell.
// ----------------------------------------------------------------------------
module nlqt_cell (
  input  logic            clk,
  input  logic            rst,
  input  nlqt_pkg::token_t tok_in,
  output nlqt_pkg::token_t tok_out,
  input  logic            prev_valid,
  output logic            valid,
  input  nlqt_pkg::wb_t   wb
);

  logic [31:0]     addr;
  nlqt_pkg::entry_t ent;
  logic            hit;
  logic            sel;

  assign hit = valid && (addr == tok_in.addr) && !tok_in.found;
  // entries fill from index 0 up, so the first free cell follows a valid one
  assign sel = wb.en && (wb.insert ? (!valid && prev_valid)
                                   : (valid && (addr == wb.addr)));

  always_ff @(posedge clk) begin
    tok_out.addr <= tok_in.addr;
    if (hit) begin
      tok_out.found <= 1'b1;
      tok_out.ent   <= ent;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.ent   <= tok_in.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && wb.insert) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      addr <= wb.addr;
      ent  <= wb.ent;
    end
  end

endmodule

### design/nlqt_blend.sv
// ----------------------------------------------------------------------------
// nlqt_blend: two-stage moving average update of one entry
// Stage one registers the weighted products, stage two rounds and merges.
// ----------------------------------------------------------------------------
module nlqt_blend #(
  parameter int MAX_RETX = 15
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [nlqt_pkg::ALPHA_W-1:0]  alpha_rx,
  input  logic [nlqt_pkg::ALPHA_W-1:0]  alpha_tx,
  input  logic [nlqt_pkg::ALPHA_W-1:0]  alpha_dl,
  input  nlqt_pkg::obs_t                item,
  input  nlqt_pkg::entry_t              base,
  output nlqt_pkg::entry_t              result
);

  localparam int AW = nlqt_pkg::ALPHA_W;
  localparam int VW = nlqt_pkg::AVG_W;
  localparam int DW = nlqt_pkg::DL_W;
  localparam logic [7:0] MAXC = 8'(MAX_RETX);

  logic [AW-1:0] a_rx, a_tx, a_dl;
  logic [7:0]    c_rx, c_tx;

  assign a_rx = nlqt_pkg::clamp_alpha(alpha_rx);
  assign a_tx = nlqt_pkg::clamp_alpha(alpha_tx);
  assign a_dl = nlqt_pkg::clamp_alpha(alpha_dl);
  assign c_rx = (item.rx_count > MAXC) ? MAXC : item.rx_count;
  assign c_tx = (item.tx_count > MAXC) ? MAXC : item.tx_count;

  // stage one
  logic [AW+7:0]    rx_pn, tx_pn;
  logic [AW+VW-1:0] rx_po, tx_po;
  logic [7:0]       rx_c, tx_c;
  logic [AW-1:0]    dl_a;
  logic [AW+DW-1:0] dl_po;
  nlqt_pkg::entry_t base_q;

  always_ff @(posedge clk) begin
    if (load) begin
      rx_pn  <= (AW+8)'(a_rx) * (AW+8)'(c_rx);
      tx_pn  <= (AW+8)'(a_tx) * (AW+8)'(c_tx);
      rx_po  <= (AW+VW)'(nlqt_pkg::Q8_ONE - a_rx) * (AW+VW)'(base.rx_avg);
      tx_po  <= (AW+VW)'(nlqt_pkg::Q8_ONE - a_tx) * (AW+VW)'(base.tx_avg);
      rx_c   <= c_rx;
      tx_c   <= c_tx;
      dl_a   <= a_dl;
      dl_po  <= (AW+DW)'(nlqt_pkg::Q8_ONE - a_dl) * (AW+DW)'(base.dl_avg);
      base_q <= base;
    end
  end

  // stage two: (a*sample + (256-a)*old + 128) >> 8
  logic [AW+VW:0]   rx_sum, tx_sum;
  logic [AW+DW-1:0] dl_sum;
  logic [VW-1:0]    rx_blend, tx_blend;
  logic [DW-1:0]    dl_blend;

  assign rx_sum = (AW+VW+1)'({rx_pn, 8'h00}) + (AW+VW+1)'(rx_po) + (AW+VW+1)'(128);
  assign tx_sum = (AW+VW+1)'({tx_pn, 8'h00}) + (AW+VW+1)'(tx_po) + (AW+VW+1)'(128);
  assign dl_sum = (item.outcome_success ? (AW+DW)'({dl_a, 8'h00}) : (AW+DW)'(0))
                + dl_po + (AW+DW)'(128);
  assign rx_blend = rx_sum[8 +: VW];
  assign tx_blend = tx_sum[8 +: VW];
  assign dl_blend = dl_sum[8 +: DW];

  always_comb begin
    result = base_q;
    if (item.rx_count_valid) begin
      result.rx_avg = base_q.known[nlqt_pkg::FLAG_RX] ? rx_blend : VW'({rx_c, 8'h00});
      result.known[nlqt_pkg::FLAG_RX] = 1'b1;
    end
    if (item.tx_count_valid) begin
      result.tx_avg = base_q.known[nlqt_pkg::FLAG_TX] ? tx_blend : VW'({tx_c, 8'h00});
      result.known[nlqt_pkg::FLAG_TX] = 1'b1;
    end
    if (item.outcome_valid) begin
      if (base_q.known[nlqt_pkg::FLAG_DL]) begin
        result.dl_avg = dl_blend;
      end else begin
        result.dl_avg = item.outcome_success ? nlqt_pkg::DL_ONE : DW'(0);
      end
      result.known[nlqt_pkg::FLAG_DL] = 1'b1;
    end
  end

endmodule

### design/neighbor_link_quality_table.sv
// ----------------------------------------------------------------------------
// neighbor_link_quality_table: per-neighbor link quality estimator
// Usage:
//   obs channel (obs_valid / obs_stall / obs): one transfer names a neighbor
//   address and optionally carries rx and tx retransmission counts and a
//   delivery outcome. res channel (res_valid / res_stall / res): one transfer
//   per observation with the entry's estimates after the update, or the
//   table_full flag when a new neighbor found no free entry.
//   cfg port: cfg_wr_en writes cfg_data into the smoothing weight chosen by
//   cfg_index; write only while the block is idle.
// Timing: one observation at a time. The next observation is accepted only
//   after the last one is written back: the search token walks the row of
//   cells at one cell per cycle, then the blend arithmetic (S_CALC) and
//   write-back (S_FIN) follow. The result register loads at write-back.
// Reset clears every entry's valid bit and sets all weights to 64 (0.25);
//   no clearing pass is needed.
// A stalled result waits in the output register while the next observation
//   is taken and searched; it then holds at write-back until res is free.
// ----------------------------------------------------------------------------
module neighbor_link_quality_table #(
  parameter int TABLE_ENTRIES       = 64,
  parameter int MAX_RETRANSMISSIONS = 15
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             obs_valid,
  output logic                             obs_stall,
  input  nlqt_pkg::obs_t                   obs,
  output logic                             res_valid,
  input  logic                             res_stall,
  output nlqt_pkg::res_t                   res,
  input  logic                             cfg_wr_en,
  input  logic [nlqt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nlqt_pkg::ALPHA_W-1:0]     cfg_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_CALC = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [IW-1:0] cnt;

  // smoothing weights
  logic [nlqt_pkg::ALPHA_W-1:0] alpha_rx, alpha_tx, alpha_dl;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_rx <= 9'd64;
      alpha_tx <= 9'd64;
      alpha_dl <= 9'd64;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nlqt_pkg::REG_ALPHA_RECEIVED: alpha_rx <= cfg_data;
        nlqt_pkg::REG_ALPHA_SENT:     alpha_tx <= cfg_data;
        nlqt_pkg::REG_ALPHA_DELIVERY: alpha_dl <= cfg_data;
        default: ;  // no register there
      endcase
    end
  end

  // current observation, held for the whole item
  nlqt_pkg::obs_t item;
  logic obs_xfer;
  assign obs_stall = (state != S_IDLE);
  assign obs_xfer  = obs_valid && !obs_stall;

  always_ff @(posedge clk) begin
    if (obs_xfer) begin
      item <= obs;
    end
  end

  // cell row: tok[i] enters cell i; vld[i] is the valid bit of cell i-1
  nlqt_pkg::token_t tok [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES:0] vld;
  nlqt_pkg::wb_t wb;

  assign tok[0].addr  = item.neighbor_address;
  assign tok[0].found = 1'b0;
  assign tok[0].ent   = '0;
  assign vld[0]       = 1'b1;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    nlqt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .prev_valid (vld[i]),
      .valid      (vld[i+1]),
      .wb         (wb)
    );
  end

  // decision once the token leaves the last cell; the table is full exactly
  // when the last cell is valid since entries fill in order
  logic has_obs;
  logic d_hit, d_ins, d_full;
  nlqt_pkg::entry_t base;
  nlqt_pkg::entry_t upd;

  assign has_obs = item.rx_count_valid || item.tx_count_valid || item.outcome_valid;
  assign base    = tok[TABLE_ENTRIES].found ? tok[TABLE_ENTRIES].ent : '0;

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      d_hit  <= tok[TABLE_ENTRIES].found;
      d_ins  <= !tok[TABLE_ENTRIES].found && has_obs && !vld[TABLE_ENTRIES];
      d_full <= !tok[TABLE_ENTRIES].found && has_obs && vld[TABLE_ENTRIES];
    end
  end

  nlqt_blend #(
    .MAX_RETX (MAX_RETRANSMISSIONS)
  ) u_blend (
    .clk      (clk),
    .load     (state == S_CALC),
    .alpha_rx (alpha_rx),
    .alpha_tx (alpha_tx),
    .alpha_dl (alpha_dl),
    .item     (item),
    .base     (base),
    .result   (upd)
  );

  // finish: output register must be free (empty or being taken)
  logic fin_go;
  assign fin_go = (state == S_FIN) && (!res_valid || !res_stall);

  always_comb begin
    wb.en     = fin_go && (d_hit || d_ins);
    wb.insert = d_ins;
    wb.addr   = item.neighbor_address;
    wb.ent    = upd;
  end

  nlqt_pkg::res_t res_next;
  always_comb begin
    res_next = '0;
    if (d_hit || d_ins) begin
      res_next.was_present       = d_hit;
      res_next.rx_known          = upd.known[nlqt_pkg::FLAG_RX];
      res_next.rx_estimate       = upd.rx_avg[11:0];
      res_next.tx_known          = upd.known[nlqt_pkg::FLAG_TX];
      res_next.tx_estimate       = upd.tx_avg[11:0];
      res_next.delivery_known    = upd.known[nlqt_pkg::FLAG_DL];
      res_next.delivery_estimate = upd.dl_avg;
    end else begin
      res_next.table_full = d_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res <= res_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (obs_xfer) state_next = S_WALK;
      S_WALK:  if (cnt == LAST) state_next = S_CALC;
      S_CALC:  state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (obs_xfer) begin
        cnt <= '0;
      end else if (state == S_WALK) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // checks
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    obs_xfer |=> (state == S_WALK))
    else $error("accepted transfer did not start the search");

  a_calc_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> ($past(state) == S_WALK) && ($past(cnt) == LAST))
    else $error("search left the cell row early");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    (wb.en && wb.insert) |-> !vld[TABLE_ENTRIES])
    else $error("insert into a full table");

  a_hit_or_insert: assert property (@(posedge clk) disable iff (rst)
    fin_go |-> !(d_hit && d_ins) && !(d_ins && d_full))
    else $error("conflicting table decision");

  a_res_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_FIN))
    else $error("result raised outside write-back");

endmodule
